FILE: hw/rtl/crq_pkg.sv
// Shared constants and types of the reachability query block.
`timescale 1ns / 1ps

package crq_pkg;

  localparam int unsigned NODES  = 64;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef logic [NODES-1:0]  row_t;
  typedef logic [NODE_W-1:0] node_t;

  // Predecessor store access for one cycle.
  typedef struct packed {
    logic  clr;
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    row_t  wr_data;
  } pred_req_t;

  // Next node chosen by the walker.
  typedef struct packed {
    logic  any;
    node_t node;
  } pick_t;

endpackage

FILE: hw/rtl/crq_pred_store.sv
// Predecessor row memory with per-row valid bits and registered read.
`timescale 1ns / 1ps

module crq_pred_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crq_pkg::pred_req_t  req_i,
  output crq_pkg::row_t       row_o
);

  crq_pkg::row_t             mem [crq_pkg::NODES];
  logic [crq_pkg::NODES-1:0] row_valid_q;
  logic                      rd_valid_q;
  crq_pkg::row_t             rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_valid_q <= '0;
      end else if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
      end
    end
  end

  // A row never written since the last clear reads as empty.
  assign row_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/crq_walker.sv
// Backward walk sets and lowest pending node search.
`timescale 1ns / 1ps

module crq_walker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           step_i,
  input  crq_pkg::row_t  row_i,
  output crq_pkg::pick_t pick_o,
  output crq_pkg::row_t  visited_o
);

  crq_pkg::row_t pending_q, pending_d;
  crq_pkg::row_t visited_q, visited_d;
  crq_pkg::row_t merged;
  crq_pkg::row_t pick_bit;
  crq_pkg::node_t low_node;

  // Fold in the row read for the node picked last cycle.
  assign merged = (pending_q | row_i) & ~visited_q;

  always_comb begin
    low_node = '0;
    for (int i = crq_pkg::NODES - 1; i >= 0; i--) begin
      if (merged[i]) begin
        low_node = crq_pkg::node_t'(i);
      end
    end
  end

  assign pick_o.any  = |merged;
  assign pick_o.node = low_node;
  assign pick_bit    = crq_pkg::row_t'(1) << low_node;

  always_comb begin
    pending_d = pending_q;
    visited_d = visited_q;
    if (start_i) begin
      pending_d = '0;
      visited_d = '0;
    end else if (step_i && pick_o.any) begin
      visited_d = visited_q | pick_bit;
      pending_d = merged & ~pick_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      visited_q <= '0;
    end else begin
      pending_q <= pending_d;
      visited_q <= visited_d;
    end
  end

  assign visited_o = visited_q;

endmodule

FILE: hw/rtl/cfg_reachability_query.sv
// Top level: sequencer, column cache and result register of the reachability engine.
//
// Input channel: in_valid_i / in_stall_o carry one transaction with operation_i,
// src_block_i, dst_block_i, src_pos_i and dst_pos_i. It is taken on a rising edge
// with in_valid_i high and in_stall_o low. Operations: clear graph, add edge, query.
// Output channel: out_valid_o / out_stall_i carry reachable_o and from_cache_o,
// exactly one result transaction per input transaction, in order.
// Path from the accepting edge to out_valid_o: clear, same-block query and unused
// codes go straight to the finishing state; add edge reads, then writes the
// predecessor row; a cached query reads, then checks its cached column. An uncached
// query walks the predecessor rows one node per cycle through the single read port
// of the predecessor memory, then writes its column to the cache. The block takes
// one transaction at a time; in_stall_o is high from acceptance until the result
// has moved into the output register. Reset empties the graph and drops all cached
// columns at once (valid bits); no clearing pass runs. A stalled result holds in
// the output register, and a finished item waits for that register before the next
// transaction is taken.
`timescale 1ns / 1ps

module cfg_reachability_query (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [crq_pkg::OP_W-1:0]        operation_i,
  input  logic [crq_pkg::NODE_W-1:0]      src_block_i,
  input  logic [crq_pkg::NODE_W-1:0]      dst_block_i,
  input  logic [crq_pkg::POS_W-1:0]       src_pos_i,
  input  logic [crq_pkg::POS_W-1:0]       dst_pos_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            reachable_o,
  output logic                            from_cache_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EDGE_RD = 8'b0000_0010,
    ST_EDGE_WR = 8'b0000_0100,
    ST_HIT_RD  = 8'b0000_1000,
    ST_HIT_CHK = 8'b0001_0000,
    ST_WALK_RD = 8'b0010_0000,
    ST_WALK    = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  crq_pkg::node_t       src_q, src_d;
  crq_pkg::node_t       dst_q, dst_d;
  crq_pkg::row_t        analyzed_q, analyzed_d;
  logic                 res_reach_q, res_reach_d;
  logic                 res_cache_q, res_cache_d;
  logic                 out_valid_q, out_valid_d;
  logic                 reachable_q, reachable_d;
  logic                 from_cache_q, from_cache_d;

  crq_pkg::pred_req_t   pred_req;
  crq_pkg::row_t        pred_row;
  crq_pkg::pick_t       pick;
  crq_pkg::row_t        visited;
  logic                 walk_start;
  logic                 walk_step;

  crq_pkg::row_t        reach_mem [crq_pkg::NODES];
  crq_pkg::row_t        reach_rd_q;
  logic                 reach_rd_en;
  logic                 reach_wr_en;
  logic                 accept;
  logic                 out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  crq_pred_store u_pred_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pred_req),
    .row_o  (pred_row)
  );

  crq_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (walk_start),
    .step_i    (walk_step),
    .row_i     (pred_row),
    .pick_o    (pick),
    .visited_o (visited)
  );

  // Cached columns; an entry is read only while its analyzed bit is set.
  always_ff @(posedge clk_i) begin
    if (reach_wr_en) begin
      reach_mem[dst_q] <= visited;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reach_rd_en) begin
      reach_rd_q <= reach_mem[dst_q];
    end
  end

  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    dst_d        = dst_q;
    analyzed_d   = analyzed_q;
    res_reach_d  = res_reach_q;
    res_cache_d  = res_cache_q;
    pred_req     = '0;
    walk_start   = 1'b0;
    walk_step    = 1'b0;
    reach_rd_en  = 1'b0;
    reach_wr_en  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          src_d       = src_block_i;
          dst_d       = dst_block_i;
          res_reach_d = 1'b0;
          res_cache_d = 1'b0;
          case (operation_i)
            crq_pkg::OP_CLEAR: begin
              pred_req.clr = 1'b1;
              analyzed_d   = '0;
              state_d      = ST_FIN;
            end
            crq_pkg::OP_EDGE: begin
              state_d = ST_EDGE_RD;
            end
            crq_pkg::OP_QUERY: begin
              if (src_block_i == dst_block_i) begin
                res_reach_d = (src_pos_i <= dst_pos_i);
                state_d     = ST_FIN;
              end else if (analyzed_q[dst_block_i]) begin
                state_d = ST_HIT_RD;
              end else begin
                state_d = ST_WALK_RD;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_EDGE_RD: begin
        pred_req.rd_en   = 1'b1;
        pred_req.rd_addr = dst_q;
        state_d          = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        pred_req.wr_en   = 1'b1;
        pred_req.wr_addr = dst_q;
        pred_req.wr_data = pred_row | (crq_pkg::row_t'(1) << src_q);
        // Any new edge may change every column: drop the whole cache.
        analyzed_d       = '0;
        state_d          = ST_FIN;
      end
      ST_HIT_RD: begin
        reach_rd_en = 1'b1;
        state_d     = ST_HIT_CHK;
      end
      ST_HIT_CHK: begin
        res_reach_d = reach_rd_q[src_q];
        res_cache_d = 1'b1;
        state_d     = ST_FIN;
      end
      ST_WALK_RD: begin
        pred_req.rd_en   = 1'b1;
        pred_req.rd_addr = dst_q;
        walk_start       = 1'b1;
        state_d          = ST_WALK;
      end
      ST_WALK: begin
        walk_step = 1'b1;
        if (pick.any) begin
          pred_req.rd_en   = 1'b1;
          pred_req.rd_addr = pick.node;
        end else begin
          reach_wr_en        = 1'b1;
          analyzed_d[dst_q]  = 1'b1;
          res_reach_d        = visited[src_q];
          state_d            = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load in the finishing state, hold while stalled.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    reachable_d  = reachable_q;
    from_cache_d = from_cache_q;
    if ((state_q == ST_FIN) && out_free) begin
      out_valid_d  = 1'b1;
      reachable_d  = res_reach_q;
      from_cache_d = res_cache_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      analyzed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      analyzed_q  <= analyzed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    dst_q        <= dst_d;
    res_reach_q  <= res_reach_d;
    res_cache_q  <= res_cache_d;
    reachable_q  <= reachable_d;
    from_cache_q <= from_cache_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign reachable_o  = reachable_q;
  assign from_cache_o = from_cache_q;

endmodule
